/* hw/rtl/mtg_pkg.sv */
// mtg_pkg: shared types and constants of the mt19937 generator
// used by mtg_ctrl, mtg_datapath and mersenne_twister_generator; no dependencies

package mtg_pkg;

    localparam int unsigned TBL_WORDS = 624;
    localparam int unsigned TBL_SHIFT = 397;
    localparam int unsigned IDX_W     = 10;

    localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(TBL_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_FULL     = IDX_W'(TBL_WORDS);
    localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(TBL_WORDS + 1);
    localparam logic [IDX_W-1:0] FAR_FWD      = IDX_W'(TBL_SHIFT);
    localparam logic [IDX_W-1:0] FAR_BACK     = IDX_W'(TBL_WORDS - TBL_SHIFT);

    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] TWIST_MAT    = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_TW_PRIME,
        ST_TW_RUN,
        ST_READ,
        ST_TEMPER
    } state_t;

    // commands from controller to datapath, at most one per cycle
    typedef struct packed {
        logic seed_user;   // latch seed from the item
        logic seed_dflt;   // latch the default seed
        logic seed_step;   // write one word of the seed fill
        logic tw_prime;    // first read of a twist pass
        logic tw_issue;    // issue reads for one twisted word
        logic rd_issue;    // read the word at the index
        logic out_ld;      // temper and load the output register
    } cmd_t;

    typedef struct packed {
        logic             cnt_last;
        logic             idx_unseeded;
        logic             idx_full;
        logic             out_busy;
        logic [IDX_W-1:0] idx;
    } status_t;

endpackage

/* hw/rtl/mtg_datapath.sv */
// mtg_datapath: state table memory, seed fill, in-place twist, tempering, output register
// depends on mtg_pkg

module mtg_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  mtg_pkg::cmd_t    cmd,
    output mtg_pkg::status_t st,
    input  logic [31:0]      seed,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata
);
    import mtg_pkg::*;

    logic [31:0]      state_mem [TBL_WORDS];
    logic [31:0]      rda_reg;
    logic [31:0]      rdb_reg;
    logic [31:0]      cur_reg;
    logic [31:0]      prev_reg;
    logic [31:0]      seed_reg;
    logic [31:0]      out_data_reg;
    logic             out_valid_reg;
    logic             wr_v_reg;
    logic [IDX_W-1:0] wr_k_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] idx_reg;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata;
    logic             ra_en;
    logic [IDX_W-1:0] ra_addr;
    logic [IDX_W-1:0] rb_addr;
    logic [31:0]      prev_mix;
    logic [31:0]      seed_prod;
    logic [31:0]      seed_val;
    logic [31:0]      tw_y;
    logic [31:0]      tw_val;
    logic             cnt_last;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    assign cnt_last = (cnt_reg == IDX_LAST);

    // seed fill recurrence, one word per cycle
    assign prev_mix  = prev_reg ^ (prev_reg >> 30);
    assign seed_prod = INIT_MULT * prev_mix;
    assign seed_val  = (cnt_reg == '0) ? seed_reg : (seed_prod + 32'(cnt_reg));

    // twist of word k from old word k, old word k+1 and word k+397
    assign tw_y   = {cur_reg[31], rda_reg[30:0]};
    assign tw_val = rdb_reg ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_MAT : 32'h0);

    always_comb
    begin
        we    = cmd.seed_step | wr_v_reg;
        waddr = cmd.seed_step ? cnt_reg : wr_k_reg;
        wdata = cmd.seed_step ? seed_val : tw_val;
    end

    always_comb
    begin
        ra_en   = cmd.tw_prime | cmd.tw_issue | cmd.rd_issue;
        ra_addr = '0;
        if (cmd.tw_issue)
        begin
            ra_addr = cnt_last ? '0 : cnt_reg + 1'b1;
        end
        else if (cmd.rd_issue)
        begin
            ra_addr = idx_reg;
        end
        rb_addr = (cnt_reg < FAR_BACK) ? cnt_reg + FAR_FWD : cnt_reg - FAR_BACK;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            state_mem[waddr] <= wdata;
        end
        if (ra_en)
        begin
            rda_reg <= state_mem[ra_addr];
        end
        if (cmd.tw_issue)
        begin
            rdb_reg <= state_mem[rb_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_user)
        begin
            seed_reg <= seed;
        end
        else if (cmd.seed_dflt)
        begin
            seed_reg <= DEFAULT_SEED;
        end
        if (cmd.seed_step)
        begin
            prev_reg <= seed_val;
        end
        if ((cmd.tw_issue && cnt_reg == '0) || wr_v_reg)
        begin
            cur_reg <= rda_reg;
        end
        wr_k_reg <= cnt_reg;
        if (cmd.out_ld)
        begin
            out_data_reg <= temper(rda_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= IDX_UNSEEDED;
            wr_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_v_reg <= cmd.tw_issue;
            if (cmd.seed_user || cmd.seed_dflt || cmd.tw_prime)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.seed_step || cmd.tw_issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.seed_step && cnt_last)
            begin
                idx_reg <= IDX_FULL;
            end
            else if (cmd.tw_issue && cnt_last)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd_issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.cnt_last     = cnt_last;
    assign st.idx_unseeded = (idx_reg > IDX_FULL);
    assign st.idx_full     = (idx_reg == IDX_FULL);
    assign st.out_busy     = out_valid_reg & ~m_tready;
    assign st.idx          = idx_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/mtg_ctrl.sv */
// mtg_ctrl: sequencing state machine for seed fill, twist pass and draw
// depends on mtg_pkg

module mtg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tuser,
    input  mtg_pkg::status_t st,
    output mtg_pkg::cmd_t    cmd
);
    import mtg_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   pending_reg;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser || st.idx_unseeded)
                    begin
                        state_next = ST_SEED;
                    end
                    else if (st.idx_full)
                    begin
                        state_next = ST_TW_PRIME;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SEED:
            begin
                if (st.cnt_last)
                begin
                    state_next = pending_reg ? ST_TW_PRIME : ST_IDLE;
                end
            end
            ST_TW_PRIME: state_next = ST_TW_RUN;
            ST_TW_RUN:
            begin
                if (st.cnt_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_TEMPER;
            ST_TEMPER:
            begin
                if (!st.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.seed_user = s_tuser;
                    cmd.seed_dflt = ~s_tuser & st.idx_unseeded;
                end
            end
            ST_SEED:     cmd.seed_step = 1'b1;
            ST_TW_PRIME: cmd.tw_prime  = 1'b1;
            ST_TW_RUN:   cmd.tw_issue  = 1'b1;
            ST_READ:     cmd.rd_issue  = 1'b1;
            ST_TEMPER:   cmd.out_ld    = ~st.out_busy;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.seed_user)
            begin
                pending_reg <= 1'b0;
            end
            else if (cmd.seed_dflt)
            begin
                pending_reg <= 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/mersenne_twister_generator.sv */
// mersenne_twister_generator: top level of the mt19937 random word generator
// depends on mtg_pkg, mtg_ctrl and mtg_datapath

// Standard 32-bit MT19937 generator with one item in flight at a time. An input item with
// s_tuser high reseeds: the 624-word table is filled from s_tdata with the usual init
// recurrence (one word per cycle from the multiplier loop) and no result comes out. An
// item with s_tuser low draws one tempered word on m_tdata: the word at the index is read
// and tempered into the output register once it is free. The first draw after a seed fill
// and every 624th draw after it first run a full in-place twist of the table, one word per
// cycle through the two read ports and one write port of the table memory. A draw with no
// earlier reseed first seeds with the default 5489 and then twists. The output register
// lets the next item be accepted while a result still waits on m_tready.

module mersenne_twister_generator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed
    input  logic        s_tuser,   // [0] operation: 0 draw, 1 reseed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] random_word
);
    import mtg_pkg::*;

    cmd_t    cmd;
    status_t st;

    // sequencer: decides seed fill, twist pass and draw steps
    mtg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .st       (st),
        .cmd      (cmd)
    );

    // table memory, word index, tempering and the output register
    mtg_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .seed     (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // at most one command per cycle
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("mtg: more than one datapath command in a cycle");

    // word index never leaves the range up to the unseeded mark
    assert property (@(posedge clk) disable iff (!rst_n) st.idx <= IDX_UNSEEDED)
        else $error("mtg: word index out of range");

    // a reseed item never makes a result appear in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !$rose(m_tvalid))
        else $error("mtg: reseed produced a result");

    // loading the output register always shows a valid result next cycle
    assert property (@(posedge clk) disable iff (!rst_n) cmd.out_ld |=> m_tvalid)
        else $error("mtg: loaded result not presented");

endmodule
